FILE: hdl/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// types and constants for the echo pulse range meter: measurement phases,
// arithmetic sequencer states, status codes, register indexes, reset values
// ----------------------------------------------------------------------------
package epr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_RISE,
        PH_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_AVG,
        SEQ_DIST
    } seq_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [2:0] CFG_SETTLE   = 3'd0;
    localparam logic [2:0] CFG_RISE     = 3'd1;
    localparam logic [2:0] CFG_FALL     = 3'd2;
    localparam logic [2:0] CFG_MIN      = 3'd3;
    localparam logic [2:0] CFG_STRENGTH = 3'd4;

    localparam logic [15:0] SETTLE_RST   = 16'd500;
    localparam logic [15:0] RISE_RST     = 16'd5000;
    localparam logic [15:0] FALL_RST     = 16'd30000;
    localparam logic [15:0] MIN_RST      = 16'd100;
    localparam logic [3:0]  STRENGTH_RST = 4'd0;

    localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
    localparam logic [15:0] WIDTH_MAX    = 16'hFFFF;

    // distance = width * 10 / 58
    localparam logic [5:0]  DIST_DIVISOR = 6'd58;
    localparam int          MUL_STEPS    = 4;
    localparam int          DIV_STEPS    = 20;

endpackage

FILE: hdl/echo_pulse_range_meter.sv
// ----------------------------------------------------------------------------
// echo_pulse_range_meter
// ultrasonic time-of-flight sequencer: trigger, settle/rise/high timing,
// exponential width average and bit-serial conversion to millimetres
// ----------------------------------------------------------------------------
//  port group   direction  handshake           word
//  s_*          in         s_valid / s_ready   start_req, us_tick, echo
//  m_*          out        m_valid / m_ready   trigger, done_res, status,
//                                              range_mm, pulse_us
//  cfg_*        in         cfg_wr_en           cfg_index, cfg_wdata
//
//  most words give their result in the cycle after acceptance
//  a good echo width runs a shift-add multiply and two restoring divisions
//  on one shared serial divider (only the distance division on the
//  first good width, which seeds the average)
//  s_ready is low while the multiply or divider runs or an unaccepted result waits in the output reg
//  reset is synchronous, active low, and loads the register defaults
// ----------------------------------------------------------------------------
module echo_pulse_range_meter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic        s_us_tick,
    input  logic        s_echo,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_trigger,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [13:0] m_range_mm,
    output logic [15:0] m_pulse_us
);

    logic [15:0] settle_limit_reg;
    logic [15:0] rise_limit_reg;
    logic [15:0] fall_limit_reg;
    logic [15:0] min_width_reg;
    logic [3:0]  strength_reg;

    epr_pkg::phase_t phase_reg, phase_next;
    epr_pkg::seq_t   seq_reg,   seq_next;
    logic [16:0] elapsed_reg,  elapsed_next;
    logic [15:0] smooth_reg,   smooth_next;
    logic        first_reg,    first_next;
    logic [15:0] last_width_reg, last_width_next;
    logic [4:0]  cnt_reg,      cnt_next;
    logic [19:0] num_reg,      num_next;
    logic [5:0]  rem_reg,      rem_next;

    logic        m_valid_reg,  m_valid_next;
    logic        trig_reg,     trig_next;
    logic        done_reg,     done_next;
    logic [1:0]  status_reg,   status_next;
    logic [13:0] dist_reg,     dist_next;
    logic [15:0] pulse_reg,    pulse_next;

    logic [16:0] el_inc;
    logic [15:0] limit;
    logic        advance;
    logic [15:0] width;
    logic [19:0] mul_step;
    logic [6:0]  div_r;
    logic [6:0]  div_d;
    logic [6:0]  div_sub;
    logic        div_ge;
    logic [19:0] div_num;
    logic [5:0]  div_rem;
    logic [15:0] avg_q;

    assign s_ready       = (seq_reg == epr_pkg::SEQ_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid       = m_valid_reg;
    assign m_trigger     = trig_reg;
    assign m_done_res    = done_reg;
    assign m_status      = status_reg;
    assign m_range_mm    = dist_reg;
    assign m_pulse_us    = pulse_reg;

    // phase timing terms
    always_comb begin
        el_inc = (elapsed_reg < epr_pkg::ELAPSED_MAX)
               ? 17'(elapsed_reg + {16'b0, s_us_tick}) : elapsed_reg;
        width  = el_inc[16] ? epr_pkg::WIDTH_MAX : el_inc[15:0];
        case (phase_reg)
            epr_pkg::PH_SETTLE: begin
                limit   = settle_limit_reg;
                advance = !s_echo;
            end
            epr_pkg::PH_RISE: begin
                limit   = rise_limit_reg;
                advance = s_echo;
            end
            epr_pkg::PH_HIGH: begin
                limit   = fall_limit_reg;
                advance = !s_echo;
            end
            default: begin
                limit   = 16'd0;
                advance = 1'b0;
            end
        endcase
    end

    // serial multiply and restoring divide datapath
    always_comb begin
        mul_step = 20'({num_reg[18:0], 1'b0})
                 + (strength_reg[~cnt_reg[1:0]] ? {4'b0, smooth_reg} : 20'd0);
        div_d    = (seq_reg == epr_pkg::SEQ_AVG)
                 ? 7'({3'b0, strength_reg} + 7'd1) : {1'b0, epr_pkg::DIST_DIVISOR};
        div_r    = {rem_reg, num_reg[19]};
        div_ge   = div_r >= div_d;
        div_sub  = 7'(div_r - div_d);
        div_rem  = div_ge ? div_sub[5:0] : div_r[5:0];
        div_num  = {num_reg[18:0], div_ge};
        avg_q    = div_num[15:0];
    end

    always_comb begin
        phase_next      = phase_reg;
        seq_next        = seq_reg;
        elapsed_next    = elapsed_reg;
        smooth_next     = smooth_reg;
        first_next      = first_reg;
        last_width_next = last_width_reg;
        cnt_next        = cnt_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        trig_next       = trig_reg;
        done_next       = done_reg;
        status_next     = status_reg;
        dist_next       = dist_reg;
        pulse_next      = pulse_reg;

        case (seq_reg)
            epr_pkg::SEQ_IDLE: begin
                if (s_valid && s_ready) begin
                    trig_next    = 1'b0;
                    done_next    = 1'b0;
                    status_next  = epr_pkg::ST_OK;
                    dist_next    = 14'd0;
                    m_valid_next = 1'b1;
                    if (phase_reg == epr_pkg::PH_IDLE) begin
                        if (s_start_req) begin
                            trig_next    = 1'b1;
                            phase_next   = epr_pkg::PH_SETTLE;
                            elapsed_next = 17'd0;
                        end
                    end else if (advance) begin
                        elapsed_next = 17'd0;
                        case (phase_reg)
                            epr_pkg::PH_SETTLE: phase_next = epr_pkg::PH_RISE;
                            epr_pkg::PH_RISE:   phase_next = epr_pkg::PH_HIGH;
                            default: begin
                                phase_next      = epr_pkg::PH_IDLE;
                                last_width_next = width;
                                done_next       = 1'b1;
                                if (width < min_width_reg) begin
                                    status_next = epr_pkg::ST_RANGE;
                                end else begin
                                    // good width: result waits for the divider
                                    m_valid_next = 1'b0;
                                    cnt_next     = 5'd0;
                                    rem_next     = 6'd0;
                                    if (first_reg) begin
                                        first_next  = 1'b0;
                                        smooth_next = width;
                                        num_next    = 20'({width, 3'b0})
                                                    + 20'({width, 1'b0});
                                        seq_next    = epr_pkg::SEQ_DIST;
                                    end else begin
                                        num_next = 20'd0;
                                        seq_next = epr_pkg::SEQ_MUL;
                                    end
                                end
                            end
                        endcase
                    end else if (el_inc > {1'b0, limit}) begin
                        done_next    = 1'b1;
                        status_next  = epr_pkg::ST_TIMEOUT;
                        phase_next   = epr_pkg::PH_IDLE;
                        elapsed_next = 17'd0;
                    end else begin
                        elapsed_next = el_inc;
                    end
                    pulse_next = last_width_next;
                end
            end
            epr_pkg::SEQ_MUL: begin
                // old average times strength, msb of strength first
                if (cnt_reg == 5'(epr_pkg::MUL_STEPS - 1)) begin
                    num_next = 20'(mul_step + {4'b0, last_width_reg});
                    cnt_next = 5'd0;
                    seq_next = epr_pkg::SEQ_AVG;
                end else begin
                    num_next = mul_step;
                    cnt_next = 5'(cnt_reg + 5'd1);
                end
            end
            epr_pkg::SEQ_AVG: begin
                num_next = div_num;
                rem_next = div_rem;
                cnt_next = 5'(cnt_reg + 5'd1);
                if (cnt_reg == 5'(epr_pkg::DIV_STEPS - 1)) begin
                    smooth_next = avg_q;
                    num_next    = 20'({avg_q, 3'b0}) + 20'({avg_q, 1'b0});
                    rem_next    = 6'd0;
                    cnt_next    = 5'd0;
                    seq_next    = epr_pkg::SEQ_DIST;
                end
            end
            epr_pkg::SEQ_DIST: begin
                num_next = div_num;
                rem_next = div_rem;
                cnt_next = 5'(cnt_reg + 5'd1);
                if (cnt_reg == 5'(epr_pkg::DIV_STEPS - 1)) begin
                    dist_next    = div_num[13:0];
                    m_valid_next = 1'b1;
                    cnt_next     = 5'd0;
                    seq_next     = epr_pkg::SEQ_IDLE;
                end
            end
            default: begin
                seq_next = epr_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_limit_reg <= epr_pkg::SETTLE_RST;
            rise_limit_reg   <= epr_pkg::RISE_RST;
            fall_limit_reg   <= epr_pkg::FALL_RST;
            min_width_reg    <= epr_pkg::MIN_RST;
            strength_reg     <= epr_pkg::STRENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                epr_pkg::CFG_SETTLE:   settle_limit_reg <= cfg_wdata;
                epr_pkg::CFG_RISE:     rise_limit_reg   <= cfg_wdata;
                epr_pkg::CFG_FALL:     fall_limit_reg   <= cfg_wdata;
                epr_pkg::CFG_MIN:      min_width_reg    <= cfg_wdata;
                epr_pkg::CFG_STRENGTH: strength_reg     <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= epr_pkg::PH_IDLE;
            seq_reg        <= epr_pkg::SEQ_IDLE;
            elapsed_reg    <= 17'd0;
            smooth_reg     <= 16'd0;
            first_reg      <= 1'b1;
            last_width_reg <= 16'd0;
            cnt_reg        <= 5'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            elapsed_reg    <= elapsed_next;
            smooth_reg     <= smooth_next;
            first_reg      <= first_next;
            last_width_reg <= last_width_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        trig_reg   <= trig_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        dist_reg   <= dist_next;
        pulse_reg  <= pulse_next;
    end

    a_dist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_range_mm <= 14'd11299)
        else $error("distance out of range");

    a_dist_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != epr_pkg::ST_OK) |-> m_range_mm == 14'd0)
        else $error("distance on a failed measurement");

    a_trig_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_trigger && m_done_res))
        else $error("trigger and done in one word");

    a_busy_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != epr_pkg::SEQ_IDLE |-> phase_reg == epr_pkg::PH_IDLE)
        else $error("arithmetic running during a measurement");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == epr_pkg::SEQ_MUL |-> cnt_reg < 5'(epr_pkg::MUL_STEPS))
        else $error("multiply step count overrun");

endmodule
